[rtl/hsv2rgb_pkg.sv]
// shared widths, payload types and codes for the hsv to rgb pixel pipeline
// no dependencies; every other file depends on it
package hsv2rgb_pkg;

  localparam int unsigned HueW  = 16;
  localparam int unsigned SatW  = 16;
  localparam int unsigned ValW  = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned NumCh = 3;

  // position t = 6*hue + one sector, wrapped to six sectors
  localparam int unsigned PosW  = HueW + 3;
  localparam int unsigned FracW = HueW;
  localparam int unsigned ChW   = FracW + 1;  // channel level 0..1.0 in q.16
  localparam int unsigned OthW  = FracW + 2;  // sum of channels, up to 2.0
  localparam int unsigned ProdW = SatW + OthW;
  localparam int unsigned QW    = ProdW + 1;  // signed blend before brightness
  localparam int unsigned MW    = QW + ValW;
  localparam int unsigned AccW  = MW + ByteW;
  localparam int unsigned SatFracW = 12;
  localparam int unsigned OutShift = 42;

  localparam logic [PosW-1:0] PosOneSector = PosW'(1) << FracW;
  localparam logic [PosW-1:0] PosTurn      = PosW'(6) << FracW;
  localparam logic [ChW-1:0]  ChOne        = ChW'(1) << FracW;
  localparam logic [ByteW-1:0] ByteMax     = '1;

  // index of each channel within the packed output
  localparam logic [1:0] ChRed = 2'd0;
  localparam logic [1:0] ChBlu = 2'd1;
  localparam logic [1:0] ChGrn = 2'd2;

  // sector: which channel is full and which one ramps
  typedef enum logic [2:0] {
    SecRedGrn = 3'd0,
    SecRedBlu = 3'd1,
    SecBluRed = 3'd2,
    SecBluGrn = 3'd3,
    SecGrnBlu = 3'd4,
    SecGrnRed = 3'd5
  } sector_e;

  typedef logic signed [QW-1:0] q_t;
  typedef logic signed [MW-1:0] m_t;

  typedef struct packed {
    logic [HueW-1:0]        hue;
    logic [SatW-1:0]        sat;
    logic signed [ValW-1:0] val;
  } pix_t;

  typedef struct packed {
    logic [NumCh-1:0][OthW-1:0] oth;   // sum of the other two channels
    logic [OthW-1:0]            psum;
    logic [SatW-1:0]            sat;
    logic signed [ValW-1:0]     val;
  } sect_t;

  typedef struct packed {
    q_t [NumCh-1:0]         q;
    logic signed [ValW-1:0] val;
  } blend_t;

  typedef struct packed {
    m_t [NumCh-1:0] m;
  } scaled_t;

  typedef struct packed {
    logic [NumCh-1:0][ByteW-1:0] b;
  } bytes_t;

endpackage

[rtl/hsv2rgb_if.sv]
// valid/ready channel interfaces for hsv input items and rgb result items
// depends on hsv2rgb_pkg for field widths
interface hsv2rgb_hsv_if;
  logic                                valid;
  logic                                ready;
  logic [hsv2rgb_pkg::HueW-1:0]        hue_turn;
  logic [hsv2rgb_pkg::SatW-1:0]        saturation;
  logic signed [hsv2rgb_pkg::ValW-1:0] brightness;

  modport source (output valid, hue_turn, saturation, brightness, input ready);
  modport sink   (input valid, hue_turn, saturation, brightness, output ready);
endinterface

interface hsv2rgb_rgb_if;
  logic                          valid;
  logic                          ready;
  logic [hsv2rgb_pkg::ByteW-1:0] low_byte_red;
  logic [hsv2rgb_pkg::ByteW-1:0] mid_byte_blue;
  logic [hsv2rgb_pkg::ByteW-1:0] high_byte_green;

  modport source (output valid, low_byte_red, mid_byte_blue, high_byte_green,
                  input ready);
  modport sink   (input valid, low_byte_red, mid_byte_blue, high_byte_green,
                  output ready);
endinterface

[rtl/hsv2rgb_sector.sv]
// stage 1: hue sector and ramp, per-channel levels and their sums
// depends on hsv2rgb_pkg
module hsv2rgb_sector (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  hsv2rgb_pkg::pix_t   data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output hsv2rgb_pkg::sect_t  data_o
);
  import hsv2rgb_pkg::*;

  logic [PosW-1:0]           pos_raw, pos;
  logic [FracW-1:0]          frac;
  logic [ChW-1:0]            ramp_up, ramp_dn;
  logic [NumCh-1:0][ChW-1:0] lvl;
  logic [OthW-1:0]           psum;
  sect_t                     data_d, data_q;
  logic                      valid_q;

  always_comb begin
    pos_raw = (PosW'(data_i.hue) << 2) + (PosW'(data_i.hue) << 1) + PosOneSector;
    pos     = (pos_raw >= PosTurn) ? pos_raw - PosTurn : pos_raw;
    frac    = pos[FracW-1:0];
    ramp_up = ChW'(frac);
    ramp_dn = ChOne - ChW'(frac);
    lvl     = '0;
    unique case (sector_e'(pos[PosW-1:FracW]))
      SecRedGrn: begin
        lvl[ChRed] = ChOne;
        lvl[ChGrn] = ramp_dn;
      end
      SecRedBlu: begin
        lvl[ChRed] = ChOne;
        lvl[ChBlu] = ramp_up;
      end
      SecBluRed: begin
        lvl[ChRed] = ramp_dn;
        lvl[ChBlu] = ChOne;
      end
      SecBluGrn: begin
        lvl[ChBlu] = ChOne;
        lvl[ChGrn] = ramp_up;
      end
      SecGrnBlu: begin
        lvl[ChBlu] = ramp_dn;
        lvl[ChGrn] = ChOne;
      end
      default: begin
        lvl[ChGrn] = ChOne;
        lvl[ChRed] = ramp_up;
      end
    endcase
    psum = OthW'(lvl[ChRed]) + OthW'(lvl[ChBlu]) + OthW'(lvl[ChGrn]);
    for (int i = 0; i < NumCh; i++) begin
      data_d.oth[i] = psum - OthW'(lvl[i]);
    end
    data_d.psum = psum;
    data_d.sat  = data_i.sat;
    data_d.val  = data_i.val;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  // one channel full and one ramping: levels always add to between 1.0 and 2.0
  a_psum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (data_q.psum >= OthW'(ChOne)) && (data_q.psum <= (OthW'(ChOne) << 1)))
    else $error("channel level sum out of range");

endmodule

[rtl/hsv2rgb_blend.sv]
// stage 2: saturation blend, q = psum*4096 - sat*(sum of other channels)
// depends on hsv2rgb_pkg
module hsv2rgb_blend (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  hsv2rgb_pkg::sect_t  data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output hsv2rgb_pkg::blend_t data_o
);
  import hsv2rgb_pkg::*;

  logic [NumCh-1:0][ProdW-1:0] prod;
  blend_t                      data_d, data_q;
  logic                        valid_q;

  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      prod[i]     = ProdW'(data_i.sat) * ProdW'(data_i.oth[i]);
      data_d.q[i] = q_t'((QW'(data_i.psum) << SatFracW) - QW'(prod[i]));
    end
    data_d.val = data_i.val;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[rtl/hsv2rgb_scale.sv]
// stage 3: signed multiply of each blended channel by brightness
// depends on hsv2rgb_pkg
module hsv2rgb_scale (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  hsv2rgb_pkg::blend_t  data_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output hsv2rgb_pkg::scaled_t data_o
);
  import hsv2rgb_pkg::*;

  scaled_t data_d, data_q;
  logic    valid_q;

  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      data_d.m[i] = MW'(data_i.q[i]) * MW'(data_i.val);
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[rtl/hsv2rgb_clamp.sv]
// stage 4: times 255, truncate toward zero, clamp to a byte; output register
// depends on hsv2rgb_pkg
module hsv2rgb_clamp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  hsv2rgb_pkg::scaled_t data_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output hsv2rgb_pkg::bytes_t  data_o
);
  import hsv2rgb_pkg::*;

  logic signed [NumCh-1:0][AccW-1:0] acc;
  bytes_t                            data_d, data_q;
  logic                              valid_q;

  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      // 255*m as a shift and subtract
      acc[i] = (AccW'(data_i.m[i]) <<< ByteW) - AccW'(data_i.m[i]);
      priority if (acc[i][AccW-1] || (acc[i] == '0)) begin
        data_d.b[i] = '0;
      end else if (|acc[i][AccW-2:OutShift+ByteW]) begin
        data_d.b[i] = ByteMax;
      end else begin
        data_d.b[i] = acc[i][OutShift+ByteW-1:OutShift];
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[rtl/hsv_to_rgb_pixel.sv]
// hsv to rgb pixel converter, four register stages: sector, blend, scale, clamp
// depends on hsv2rgb_pkg, the hsv2rgb channel interfaces and the four stage modules
// throughput: 1 item per cycle while the output is not stalled
// each stage reloads in the cycle its item moves on, so items can follow back to back
// a stalled output backs up stage by stage, so up to four items are held in flight
// reset is asynchronous, active low, and clears all stage valid bits
module hsv_to_rgb_pixel (
  input  logic          clk_i,
  input  logic          rst_ni,
  hsv2rgb_hsv_if.sink   hsv_i,
  hsv2rgb_rgb_if.source rgb_o
);
  import hsv2rgb_pkg::*;

  pix_t    pix;
  sect_t   sect;
  blend_t  blend;
  scaled_t scaled;
  bytes_t  bytes;
  logic    v1, v2, v3, v4;
  logic    r1, r2, r3;
  logic [2:0] inflight_q, inflight_d;

  assign pix.hue = hsv_i.hue_turn;
  assign pix.sat = hsv_i.saturation;
  assign pix.val = hsv_i.brightness;

  hsv2rgb_sector u_sector (
    .clk_i, .rst_ni,
    .valid_i (hsv_i.valid), .ready_o (hsv_i.ready), .data_i (pix),
    .valid_o (v1), .ready_i (r1), .data_o (sect)
  );

  hsv2rgb_blend u_blend (
    .clk_i, .rst_ni,
    .valid_i (v1), .ready_o (r1), .data_i (sect),
    .valid_o (v2), .ready_i (r2), .data_o (blend)
  );

  hsv2rgb_scale u_scale (
    .clk_i, .rst_ni,
    .valid_i (v2), .ready_o (r2), .data_i (blend),
    .valid_o (v3), .ready_i (r3), .data_o (scaled)
  );

  hsv2rgb_clamp u_clamp (
    .clk_i, .rst_ni,
    .valid_i (v3), .ready_o (r3), .data_i (scaled),
    .valid_o (v4), .ready_i (rgb_o.ready), .data_o (bytes)
  );

  assign rgb_o.valid           = v4;
  assign rgb_o.low_byte_red    = bytes.b[ChRed];
  assign rgb_o.mid_byte_blue   = bytes.b[ChBlu];
  assign rgb_o.high_byte_green = bytes.b[ChGrn];

  // items accepted but not yet delivered
  always_comb begin
    inflight_d = inflight_q;
    if (hsv_i.valid && hsv_i.ready) inflight_d = inflight_d + 3'd1;
    if (rgb_o.valid && rgb_o.ready) inflight_d = inflight_d - 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  a_inflight_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 3'd4)
    else $error("more items in flight than pipeline stages");

  a_inflight_valids: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q == 3'($countones({v1, v2, v3, v4})))
    else $error("in-flight count disagrees with stage valid bits");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hsv_i.ready |-> (v1 && v2 && v3 && v4 && !rgb_o.ready))
    else $error("input stalled while the pipeline has room");

endmodule
